>>> hw/rtl/cap_touch_charge_time_sensor_assert.svh
// Assertion macros for the capacitive touch sensor checker
`ifndef CAP_TOUCH_CHARGE_TIME_SENSOR_ASSERT_SVH
`define CAP_TOUCH_CHARGE_TIME_SENSOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CTCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctcs assertion failed");

// next-cycle implication, disabled during reset
`define CTCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctcs assertion failed");

`endif

>>> hw/rtl/ctcs_pkg.sv
// Package for the capacitive touch charge-time sensor: widths, codes and state types
package ctcs_pkg;

   localparam int CountWidth = 24;
   localparam int DivCntWidth = $clog2(CountWidth);
   localparam logic [31:0] CountMax = 32'((64'd1 << CountWidth) - 64'd1);

   localparam int LimitWidth = 24;
   localparam int WindowWidth = 16;
   localparam int SampleWidth = 8;
   localparam int BurstWidth = 16;
   localparam int ReadingWidth = 25;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 24;

   localparam logic [CsrIndexWidth-1:0] CSR_TIMEOUT_LIMIT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CAL_WINDOW = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CLAMP_NEG = 2'd2;

   localparam logic [LimitWidth-1:0] TimeoutLimitReset = 24'd65535;
   localparam logic [WindowWidth-1:0] CalWindowReset = 16'd20;

   localparam logic [ReadingWidth-1:0] TimeoutCode = 25'h1FFFFFE;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_CAL = 2'd1,
      MODE_MEAS = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      PH_DISCHARGE = 3'd0,
      PH_CHARGE_WAIT = 3'd1,
      PH_TOPUP = 3'd2,
      PH_RELEASE_WAIT = 3'd3,
      PH_CHECK = 3'd4
   } phase_type;

endpackage

>>> hw/rtl/cap_touch_charge_time_sensor.sv
// Capacitive touch sensor, charge-time method, with calibration and baseline divider
// Each transfer on req_ is one sensor tick: the block samples rx_level, advances its
// charge/discharge sequencer by one step and returns one rsp_ transfer with the pin
// controls for that tick and, on the tick a reading completes, done_res, status and
// the signed reading (count minus baseline, or -2 with status 1 on timeout). A tick
// is taken every clock while req_stall is low. When a calibration window closes
// with at least one burst, the baseline is computed by a restoring divider that
// retires one quotient bit per clock, while req_stall stays high. req_stall
// is also high while a result sits in the output register and rsp_stall is high.
// Configuration writes are taken any cycle and are meant to be made while idle.
module cap_touch_charge_time_sensor import ctcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_start_req,
   input  logic [SampleWidth-1:0]   req_samples,
   input  logic                     req_rx_level,
   input  logic                     req_ms_tick,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_send_high,
   output logic                     rsp_rx_drive,
   output logic                     rsp_rx_drive_high,
   output logic                     rsp_done_res,
   output logic                     rsp_status,
   output logic signed [ReadingWidth-1:0] rsp_reading,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   // configuration
   logic [LimitWidth-1:0]  limit_ff;
   logic [WindowWidth-1:0] window_ff;
   logic                   clamp_ff;

   // sequencer state
   mode_type               mode_ff, mode_in;
   phase_type              phase_ff, phase_in;
   logic [CountWidth-1:0]  acc_ff, acc_in;
   logic [CountWidth-1:0]  base_ff;
   logic                   calibrated_ff, calibrated_in;
   logic [SampleWidth-1:0] last_cnt_ff, last_cnt_in;
   logic [SampleWidth-1:0] smp_idx_ff, smp_idx_in;
   logic [BurstWidth-1:0]  burst_ff, burst_in;
   logic [WindowWidth-1:0] elapsed_ff, elapsed_in;

   // baseline divider
   logic                   div_busy_ff;
   logic [DivCntWidth-1:0] div_cnt_ff;
   logic [BurstWidth-1:0]  div_rem_ff;
   logic [CountWidth-1:0]  div_quo_ff;
   logic [BurstWidth-1:0]  div_den_ff;
   logic [BurstWidth:0]    div_rem_sh;
   logic                   div_ge;
   logic [BurstWidth-1:0]  div_rem_next;
   logic [CountWidth-1:0]  div_quo_next;
   logic                   div_start;

   // result register
   logic                   rsp_valid_ff;
   logic                   send_high_ff, rx_drive_ff, rx_drive_high_ff;
   logic                   done_ff, status_ff;
   logic [ReadingWidth-1:0] reading_ff;

   // step outputs
   logic                   pin_send, pin_drive, pin_drive_high;
   logic                   done_in, status_in;
   logic [ReadingWidth-1:0] reading_in;

   logic                   in_fire;
   logic                   out_fire;
   logic                   limit_hit;
   logic [31:0]            limit_eff;
   logic [32:0]            diff;
   logic                   cal_mode;

   assign out_fire = rsp_valid_ff & ~rsp_stall;
   assign req_stall = div_busy_ff | (rsp_valid_ff & rsp_stall);
   assign in_fire = req_valid & ~req_stall;

   assign limit_eff = (32'(limit_ff) < CountMax) ? 32'(limit_ff) : CountMax;
   assign limit_hit = 32'(acc_ff) >= limit_eff;
   assign diff = {1'b0, 32'(acc_ff)} - {1'b0, 32'(base_ff)};
   assign cal_mode = (mode_ff == MODE_CAL);

   // pin controls follow the phase held at the start of the tick
   always_comb begin : pin_outputs
      pin_send = 1'b0;
      pin_drive = 1'b0;
      pin_drive_high = 1'b0;
      if (mode_ff == MODE_CAL || mode_ff == MODE_MEAS) begin
         case (phase_ff)
            PH_DISCHARGE: begin
               pin_drive = 1'b1;
            end
            PH_CHARGE_WAIT: begin
               pin_send = 1'b1;
            end
            PH_TOPUP: begin
               pin_send = 1'b1;
               pin_drive = 1'b1;
               pin_drive_high = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // only a measurement completes a reading
   always_comb begin : result_outputs
      done_in = 1'b0;
      status_in = 1'b0;
      reading_in = '0;
      if (mode_ff == MODE_MEAS) begin
         case (phase_ff)
            PH_CHARGE_WAIT, PH_RELEASE_WAIT: begin
               if (limit_hit) begin
                  done_in = 1'b1;
                  status_in = 1'b1;
                  reading_in = TimeoutCode;
               end
            end
            PH_DISCHARGE: begin
               if (smp_idx_ff >= last_cnt_ff) begin
                  done_in = 1'b1;
                  if (limit_hit) begin
                     status_in = 1'b1;
                     reading_in = TimeoutCode;
                  end else if (clamp_ff && diff[32]) begin
                     reading_in = '0;
                  end else begin
                     reading_in = diff[ReadingWidth-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin : step_next
      mode_in = mode_ff;
      phase_in = phase_ff;
      acc_in = acc_ff;
      calibrated_in = calibrated_ff;
      last_cnt_in = last_cnt_ff;
      smp_idx_in = smp_idx_ff;
      burst_in = burst_ff;
      elapsed_in = elapsed_ff;
      div_start = 1'b0;
      if (mode_ff == MODE_CAL || mode_ff == MODE_MEAS) begin
         case (phase_ff)
            PH_CHECK: begin
               if (!cal_mode) begin
                  phase_in = PH_DISCHARGE;
               end else if (elapsed_ff >= window_ff) begin
                  // window closed: average bursts into the baseline if any ran, then measure
                  div_start = (burst_ff != '0);
                  acc_in = '0;
                  mode_in = MODE_MEAS;
                  phase_in = PH_DISCHARGE;
                  smp_idx_in = '0;
               end else begin
                  smp_idx_in = '0;
                  phase_in = PH_DISCHARGE;
               end
            end
            PH_CHARGE_WAIT, PH_RELEASE_WAIT: begin
               if (limit_hit) begin
                  if (cal_mode) begin
                     // calibration timeout keeps the old baseline
                     acc_in = '0;
                     mode_in = MODE_MEAS;
                     phase_in = PH_DISCHARGE;
                     smp_idx_in = '0;
                  end else begin
                     mode_in = MODE_IDLE;
                     phase_in = PH_DISCHARGE;
                  end
               end else if (phase_ff == PH_CHARGE_WAIT) begin
                  if (req_rx_level) begin
                     phase_in = PH_TOPUP;
                  end else begin
                     acc_in = acc_ff + 1'b1;
                  end
               end else if (!req_rx_level) begin
                  smp_idx_in = (smp_idx_ff == '1) ? smp_idx_ff : smp_idx_ff + 1'b1;
                  phase_in = PH_DISCHARGE;
               end else begin
                  acc_in = acc_ff + 1'b1;
               end
            end
            PH_TOPUP: begin
               phase_in = PH_RELEASE_WAIT;
            end
            default: begin
               if (smp_idx_ff >= last_cnt_ff) begin
                  if (cal_mode) begin
                     burst_in = (burst_ff == '1) ? burst_ff : burst_ff + 1'b1;
                     phase_in = PH_CHECK;
                  end else begin
                     mode_in = MODE_IDLE;
                     phase_in = PH_DISCHARGE;
                  end
               end else begin
                  phase_in = PH_CHARGE_WAIT;
               end
            end
         endcase
         if (cal_mode && req_ms_tick && elapsed_ff != '1) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end else begin
         mode_in = MODE_IDLE;
         if (req_start_req) begin
            acc_in = '0;
            if (!calibrated_ff || req_samples != last_cnt_ff) begin
               last_cnt_in = req_samples;
               calibrated_in = 1'b1;
               mode_in = MODE_CAL;
               phase_in = PH_CHECK;
               burst_in = '0;
               elapsed_in = '0;
               smp_idx_in = '0;
            end else begin
               mode_in = MODE_MEAS;
               phase_in = PH_DISCHARGE;
               smp_idx_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         phase_ff <= PH_DISCHARGE;
         acc_ff <= '0;
         calibrated_ff <= 1'b0;
         last_cnt_ff <= '0;
         smp_idx_ff <= '0;
         burst_ff <= '0;
         elapsed_ff <= '0;
      end else if (in_fire) begin
         mode_ff <= mode_in;
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         calibrated_ff <= calibrated_in;
         last_cnt_ff <= last_cnt_in;
         smp_idx_ff <= smp_idx_in;
         burst_ff <= burst_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TimeoutLimitReset;
         window_ff <= CalWindowReset;
         clamp_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMEOUT_LIMIT: limit_ff <= csr_wdata[LimitWidth-1:0];
            CSR_CAL_WINDOW: window_ff <= csr_wdata[WindowWidth-1:0];
            CSR_CLAMP_NEG: clamp_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // restoring divider, one quotient bit per clock, MSB first
   assign div_rem_sh = {div_rem_ff, div_quo_ff[CountWidth-1]};
   assign div_ge = div_rem_sh >= {1'b0, div_den_ff};
   assign div_rem_next = div_ge ? BurstWidth'(div_rem_sh - {1'b0, div_den_ff})
                                : div_rem_sh[BurstWidth-1:0];
   assign div_quo_next = {div_quo_ff[CountWidth-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff <= '0;
         base_ff <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (div_cnt_ff == '0) begin
            div_busy_ff <= 1'b0;
            base_ff <= div_quo_next;
         end
      end else if (in_fire && div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff <= DivCntWidth'(CountWidth - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (div_busy_ff) begin
         div_rem_ff <= div_rem_next;
         div_quo_ff <= div_quo_next;
      end else if (in_fire && div_start) begin
         div_rem_ff <= '0;
         div_quo_ff <= acc_ff;
         div_den_ff <= burst_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         send_high_ff <= pin_send;
         rx_drive_ff <= pin_drive;
         rx_drive_high_ff <= pin_drive_high;
         done_ff <= done_in;
         status_ff <= status_in;
         reading_ff <= reading_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_send_high = send_high_ff;
   assign rsp_rx_drive = rx_drive_ff;
   assign rsp_rx_drive_high = rx_drive_high_ff;
   assign rsp_done_res = done_ff;
   assign rsp_status = status_ff;
   assign rsp_reading = reading_ff;

endmodule

>>> hw/rtl/ctcs_checker.sv
// Port-level checker for the capacitive touch sensor, bound to the top level
`include "cap_touch_charge_time_sensor_assert.svh"

module ctcs_checker import ctcs_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_send_high,
   input logic                    rsp_rx_drive,
   input logic                    rsp_rx_drive_high,
   input logic                    rsp_done_res,
   input logic                    rsp_status,
   input logic [ReadingWidth-1:0] rsp_reading
);

   logic no_reading;
   logic timeout_reading;

   assign no_reading = !rsp_status && (rsp_reading == '0);
   assign timeout_reading = rsp_done_res && (rsp_reading == TimeoutCode);

   // a stalled result stays offered
   `CTCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // status and reading are zero unless a reading completes
   `CTCS_ASSERT_IMPLY(a_idle_fields, clock, reset, rsp_valid && !rsp_done_res, no_reading)

   // timeout always carries the -2 code
   `CTCS_ASSERT_IMPLY(a_timeout_code, clock, reset, rsp_valid && rsp_status, timeout_reading)

   // pull-up on the receive pin only during top-up, with send high and pin driven
   `CTCS_ASSERT_IMPLY(a_topup_pins, clock, reset, rsp_valid && rsp_rx_drive_high, rsp_rx_drive && rsp_send_high)

endmodule

bind cap_touch_charge_time_sensor ctcs_checker u_ctcs_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the capacitive touch charge-time sensor, one tick per transfer
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ctcs_pkg::*;

   localparam int QuietLimit = 5000;
   localparam int SettleCycles = 40;
   localparam int RandTicks = 768;
   localparam int HoldCycles = 300;

   typedef struct packed {
      logic                   start;
      logic [SampleWidth-1:0] samples;
      logic                   rx;
      logic                   ms;
   } tick_type;

   typedef struct packed {
      logic                    send_high;
      logic                    rx_drive;
      logic                    rx_drive_high;
      logic                    done;
      logic                    status;
      logic [ReadingWidth-1:0] reading;
   } pin_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_start_req = 1'b0;
   logic [SampleWidth-1:0] req_samples = '0;
   logic req_rx_level = 1'b0;
   logic req_ms_tick = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_send_high;
   logic rsp_rx_drive;
   logic rsp_rx_drive_high;
   logic rsp_done_res;
   logic rsp_status;
   logic signed [ReadingWidth-1:0] rsp_reading;
   logic csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   cap_touch_charge_time_sensor DUT (.*);

   always #1 clock = ~clock;

   // sensor state as predicted from accepted ticks
   mode_type st_mode;
   phase_type st_phase;
   logic [CountWidth-1:0] st_acc, st_base;
   logic st_cal;
   logic [SampleWidth-1:0] st_last_n, st_idx;
   logic [BurstWidth-1:0] st_bursts;
   logic [WindowWidth-1:0] st_elapsed;
   logic [LimitWidth-1:0] cfg_limit;
   logic [WindowWidth-1:0] cfg_window;
   logic cfg_clamp;

   tick_type tick_q[$];
   pin_result_type pin_exp_q[$];
   int push_cnt = 0;
   int acc_cnt = 0;
   int mismatch_cnt = 0;

   // stimulus shaping
   logic rx_lvl = 1'b0;
   int rx_run = 0;
   int rx_max = 6;
   int ms_pct = 100;
   logic [SampleWidth-1:0] last_pick = 8'd2;

   function automatic void open_measurement();
      st_acc = '0;
      st_mode = MODE_MEAS;
      st_phase = PH_DISCHARGE;
      st_idx = '0;
   endfunction

   function automatic pin_result_type charge_time_step(tick_type t);
      pin_result_type r;
      logic cal;
      logic [ReadingWidth-1:0] diff;
      r = '0;
      cal = (st_mode == MODE_CAL);
      if (st_mode == MODE_CAL || st_mode == MODE_MEAS) begin
         case (st_phase)
            PH_DISCHARGE: r.rx_drive = 1'b1;
            PH_CHARGE_WAIT: r.send_high = 1'b1;
            PH_TOPUP: begin
               r.send_high = 1'b1;
               r.rx_drive = 1'b1;
               r.rx_drive_high = 1'b1;
            end
            default: ;
         endcase
         case (st_phase)
            PH_CHECK: begin
               if (!cal) begin
                  st_phase = PH_DISCHARGE;
               end else if (st_elapsed >= cfg_window) begin
                  // window closed: average the bursts, keep old baseline if none ran
                  if (st_bursts != '0) st_base = CountWidth'(st_acc / st_bursts);
                  open_measurement();
               end else begin
                  st_idx = '0;
                  st_phase = PH_DISCHARGE;
               end
            end
            PH_CHARGE_WAIT, PH_RELEASE_WAIT: begin
               if (st_acc >= cfg_limit) begin
                  if (cal) begin
                     open_measurement();
                  end else begin
                     r.done = 1'b1;
                     r.status = 1'b1;
                     r.reading = TimeoutCode;
                     st_mode = MODE_IDLE;
                     st_phase = PH_DISCHARGE;
                  end
               end else if (st_phase == PH_CHARGE_WAIT) begin
                  if (t.rx) st_phase = PH_TOPUP;
                  else st_acc++;
               end else begin
                  if (!t.rx) begin
                     st_idx++;
                     if (st_idx == '0) st_idx = '1;
                     st_phase = PH_DISCHARGE;
                  end else begin
                     st_acc++;
                  end
               end
            end
            PH_TOPUP: st_phase = PH_RELEASE_WAIT;
            default: begin
               if (st_idx >= st_last_n) begin
                  if (cal) begin
                     if (st_bursts != '1) st_bursts++;
                     st_phase = PH_CHECK;
                  end else begin
                     r.done = 1'b1;
                     if (st_acc >= cfg_limit) begin
                        r.status = 1'b1;
                        r.reading = TimeoutCode;
                     end else begin
                        diff = {1'b0, st_acc} - {1'b0, st_base};
                        if (cfg_clamp && diff[ReadingWidth-1]) diff = '0;
                        r.reading = diff;
                     end
                     st_mode = MODE_IDLE;
                     st_phase = PH_DISCHARGE;
                  end
               end else begin
                  st_phase = PH_CHARGE_WAIT;
               end
            end
         endcase
         if (cal && t.ms && st_elapsed != '1) st_elapsed++;
      end else if (t.start) begin
         st_acc = '0;
         if (!st_cal || t.samples != st_last_n) begin
            st_last_n = t.samples;
            st_cal = 1'b1;
            st_mode = MODE_CAL;
            st_phase = PH_CHECK;
            st_bursts = '0;
            st_elapsed = '0;
            st_idx = '0;
         end else begin
            open_measurement();
         end
      end
      return r;
   endfunction

   // ---------------- driver ----------------
   int burst_left = 20;
   int gap_left = 0;
   logic offer;
   pin_result_type pred;
   tick_type nxt;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         st_mode = MODE_IDLE;
         st_phase = PH_DISCHARGE;
         st_acc = '0;
         st_base = '0;
         st_cal = 1'b0;
         st_last_n = '0;
         st_idx = '0;
         st_bursts = '0;
         st_elapsed = '0;
         cfg_limit = TimeoutLimitReset;
         cfg_window = CalWindowReset;
         cfg_clamp = 1'b0;
      end else begin
         offer = !req_valid;
         if (req_valid && !req_stall) begin
            pred = charge_time_step(tick_type'{req_start_req, req_samples, req_rx_level,
                                               req_ms_tick});
            pin_exp_q.push_back(pred);
            acc_cnt++;
            offer = 1'b1;
         end
         if (offer) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
               nxt = tick_q.pop_front();
               req_start_req <= nxt.start;
               req_samples <= nxt.samples;
               req_rx_level <= nxt.rx;
               req_ms_tick <= nxt.ms;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 60);
                  gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h got %0h", $realtime, field, want, got);
   endtask

   int hold_left = 0;
   logic hold_done = 1'b0;
   int pat_left = 0;
   int pat_kind = 0;
   pin_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pin_exp_q.size() == 0) begin
               flag_mismatch("unexpected transfer", 0, 0);
            end else begin
               want = pin_exp_q.pop_front();
               if (rsp_send_high !== want.send_high)
                  flag_mismatch("send_high", want.send_high, rsp_send_high);
               if (rsp_rx_drive !== want.rx_drive)
                  flag_mismatch("rx_drive", want.rx_drive, rsp_rx_drive);
               if (rsp_rx_drive_high !== want.rx_drive_high)
                  flag_mismatch("rx_drive_high", want.rx_drive_high, rsp_rx_drive_high);
               if (rsp_done_res !== want.done)
                  flag_mismatch("done_res", want.done, rsp_done_res);
               if (rsp_status !== want.status)
                  flag_mismatch("status", want.status, rsp_status);
               if (rsp_reading !== want.reading)
                  flag_mismatch("reading", want.reading, rsp_reading);
            end
         end
         // one long hold while the sender still has ticks queued, else a roving pattern
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && tick_q.size() > 20 && acc_cnt > 300) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            rsp_stall <= 1'b1;
         end else begin
            if (pat_left == 0) begin
               pat_kind = $urandom_range(2);
               pat_left = $urandom_range(20, 120);
            end
            pat_left--;
            case (pat_kind)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(3) == 0);
               default: rsp_stall <= ($urandom_range(3) != 0);
            endcase
         end
      end
   end

   // ---------------- watchdog ----------------
   int quiet = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic next_rx();
      if (rx_run == 0) begin
         rx_lvl = ~rx_lvl;
         rx_run = $urandom_range(1, rx_max);
      end
      rx_run--;
      return rx_lvl;
   endfunction

   // mostly small sample counts, now and then a wider one
   function automatic logic [SampleWidth-1:0] pick_samples();
      int r;
      r = $urandom_range(99);
      if (r >= 50)
         last_pick = (r < 53) ? SampleWidth'($urandom_range(8, 31))
                              : SampleWidth'($urandom_range(7));
      return last_pick;
   endfunction

   function automatic void push_one(logic start, logic [SampleWidth-1:0] smp);
      tick_type t;
      t.start = start;
      t.samples = smp;
      t.rx = next_rx();
      t.ms = ($urandom_range(99) < ms_pct);
      tick_q.push_back(t);
      push_cnt++;
   endfunction

   function automatic void push_ticks(int n, int start_pct);
      for (int i = 0; i < n; i++)
         push_one($urandom_range(99) < start_pct, pick_samples());
   endfunction

   // run idle ticks until the sensor is idle and every result has been checked
   task automatic settle();
      forever begin
         while (acc_cnt != push_cnt) @(posedge clock);
         if (st_mode == MODE_IDLE) break;
         push_ticks(32, 0);
      end
      while (pin_exp_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TIMEOUT_LIMIT: cfg_limit = data[LimitWidth-1:0];
         CSR_CAL_WINDOW: cfg_window = data[WindowWidth-1:0];
         CSR_CLAMP_NEG: cfg_clamp = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned limit, int unsigned window, logic clamp);
      settle();
      write_reg(CSR_TIMEOUT_LIMIT, CsrDataWidth'(limit));
      write_reg(CSR_CAL_WINDOW, CsrDataWidth'(window));
      write_reg(CSR_CLAMP_NEG, CsrDataWidth'(clamp));
   endtask

   task automatic take_reading(logic [SampleWidth-1:0] smp);
      push_one(1'b1, smp);
      settle();
   endtask

   int rand_ticks;
   int start_pct;
   int unsigned lim;
   int unsigned win;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, first reading calibrates, second only measures
      take_reading(8'd2);
      take_reading(8'd2);
      // starts while busy are ignored
      push_one(1'b1, 8'd3);
      repeat (6) push_one(1'b1, SampleWidth'($urandom_range(255)));
      settle();
      configure(65535, 0, 1'b0);       // empty window keeps the old baseline
      take_reading(8'd4);
      configure(65535, 1, 1'b0);
      take_reading(8'd0);              // no samples per burst
      configure(0, 1, 1'b0);           // every wait tick times out
      take_reading(8'd5);
      configure(8, 2, 1'b0);           // calibration and measurement timeouts
      rx_max = 30;
      take_reading(8'd6);
      configure(65535, 1, 1'b0);       // long calibration, short measurement: below baseline
      rx_max = 20;
      take_reading(8'd2);
      rx_max = 1;
      take_reading(8'd2);
      configure(65535, 1, 1'b1);
      take_reading(8'd2);
      configure(40, 1, 1'b0);
      rx_max = 4;
      take_reading(8'd255);
      // widest window, closed early by a calibration timeout
      configure(1, 16'hFFFF, 1'b1);
      ms_pct = 45;
      take_reading(8'd1);

      // random: phases of random settings, ticks with random starts
      rand_ticks = 0;
      while (rand_ticks < RandTicks) begin
         case ($urandom_range(9))
            0: lim = 1;
            1: lim = 24'hFFFFFF;
            2, 3, 4, 5: lim = $urandom_range(2, 300);
            default: lim = 65535;
         endcase
         win = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         configure(lim, win, 1'($urandom_range(1)));
         ms_pct = $urandom_range(5, 60);
         start_pct = $urandom_range(2, 15);
         repeat (8) begin
            rx_max = $urandom_range(1, 24);
            push_ticks(32, start_pct);
            rand_ticks += 32;
         end
      end
      settle();

      if (mismatch_cnt == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ctcs_pkg.sv
hw/rtl/cap_touch_charge_time_sensor.sv
hw/rtl/ctcs_checker.sv
tb/tb_top.sv
